[rtl/kvct_pkg.sv]
// Shared types, constants and helpers of the key/value configuration tokenizer.
package kvct_pkg;

   // Offset counter width and the fixed width of reported offsets.
   localparam int OFFSET_BITS = 20;
   localparam int TOKEN_BITS  = 20;
   localparam logic [OFFSET_BITS-1:0] POS_MAX = '1;

   // Result queue geometry; the depth is a power of two so pointers wrap.
   localparam int DEPTH    = 4;
   localparam int PTR_BITS = $clog2(DEPTH);
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   // Input commands.
   localparam logic CMD_BYTE = 1'b0;
   localparam logic CMD_END  = 1'b1;

   // Characters with a meaning to the scanner.
   localparam logic [7:0] CH_HASH    = 8'h23;
   localparam logic [7:0] CH_EQUAL   = 8'h3D;
   localparam logic [7:0] CH_COMMA   = 8'h2C;
   localparam logic [7:0] CH_NEWLINE = 8'h0A;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_TAB     = 8'h09;
   localparam logic [7:0] CH_VTAB    = 8'h0B;
   localparam logic [7:0] CH_FF      = 8'h0C;
   localparam logic [7:0] CH_CR      = 8'h0D;

   typedef enum logic [2:0] {
      MODE_SEEK    = 3'd0,
      MODE_COMMENT = 3'd1,
      MODE_KEY     = 3'd2,
      MODE_VSPACE  = 3'd3,
      MODE_VALUE   = 3'd4
   } mode_type;

   typedef enum logic [1:0] {
      KIND_KEY = 2'd0,
      KIND_VAL = 2'd1,
      KIND_EOF = 2'd2
   } kind_type;

   typedef struct packed {
      kind_type                kind;
      logic [TOKEN_BITS-1:0]   token_begin;
      logic [TOKEN_BITS-1:0]   token_end;
      logic                    overflow;
      logic                    last;
   } result_type;

   // Up to two results written into the queue in one cycle.
   typedef struct packed {
      logic [1:0] count;
      result_type r0;
      result_type r1;
   } push_type;

   // Whitespace inside a line (everything but newline).
   function automatic logic is_inline_space(input logic [7:0] c);
      return c inside {CH_SPACE, CH_TAB, CH_VTAB, CH_FF, CH_CR};
   endfunction

endpackage

[rtl/kvct_scan.sv]
// Scanner state and per-transaction decode that produces up to two tokens.
module kvct_scan (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              cmd,
   input  logic [7:0]        text_byte,
   output kvct_pkg::push_type push
);

   kvct_pkg::mode_type                  mode_ff, mode_in;
   logic [kvct_pkg::OFFSET_BITS-1:0]    pos_ff, pos_in;
   logic [kvct_pkg::OFFSET_BITS-1:0]    pbeg_ff, pbeg_in;
   logic [kvct_pkg::OFFSET_BITS-1:0]    pend_ff, pend_in;
   logic                                ovf_ff, ovf_in;

   logic                                sat;
   logic [kvct_pkg::OFFSET_BITS-1:0]    nx;
   logic                                ovf_new;
   logic                                spc;

   // Build one result record with offsets cut to the reported width.
   function automatic kvct_pkg::result_type mk(
      input kvct_pkg::kind_type              k,
      input logic [kvct_pkg::OFFSET_BITS-1:0] b,
      input logic [kvct_pkg::OFFSET_BITS-1:0] e,
      input logic                            o,
      input logic                            l);
      kvct_pkg::result_type r;
      r.kind        = k;
      r.token_begin = kvct_pkg::TOKEN_BITS'(b);
      r.token_end   = kvct_pkg::TOKEN_BITS'(e);
      r.overflow    = o;
      r.last        = l;
      return r;
   endfunction

   // Saturating byte position.
   always_comb begin
      sat     = (pos_ff == kvct_pkg::POS_MAX);
      nx      = sat ? kvct_pkg::POS_MAX : pos_ff + 1'b1;
      ovf_new = ovf_ff | sat;
      spc     = kvct_pkg::is_inline_space(text_byte);
   end

   // Mode decode, pending token update and token emission.
   always_comb begin
      mode_in  = mode_ff;
      pos_in   = pos_ff;
      pbeg_in  = pbeg_ff;
      pend_in  = pend_ff;
      ovf_in   = ovf_ff;
      push     = '0;
      push.r0  = mk(kvct_pkg::KIND_EOF, '0, '0, ovf_ff, 1'b1);
      push.r1  = mk(kvct_pkg::KIND_EOF, '0, '0, ovf_ff, 1'b1);
      if (en && cmd == kvct_pkg::CMD_END) begin
         // Flush the pending token, then end of file, then rewind.
         mode_in = kvct_pkg::MODE_SEEK;
         pos_in  = '0;
         pbeg_in = '0;
         pend_in = '0;
         ovf_in  = 1'b0;
         case (mode_ff)
            kvct_pkg::MODE_KEY: begin
               push.count = 2'd2;
               push.r0    = mk(kvct_pkg::KIND_KEY, pbeg_ff, pend_ff, ovf_ff, 1'b0);
            end
            kvct_pkg::MODE_VSPACE: begin
               push.count = 2'd2;
               push.r0    = mk(kvct_pkg::KIND_VAL, pos_ff, pos_ff, ovf_ff, 1'b0);
            end
            kvct_pkg::MODE_VALUE: begin
               push.count = 2'd2;
               push.r0    = mk(kvct_pkg::KIND_VAL, pbeg_ff, pend_ff, ovf_ff, 1'b0);
            end
            default: begin
               push.count = 2'd1;
            end
         endcase
      end else if (en) begin
         pos_in = nx;
         ovf_in = ovf_new;
         case (mode_ff)
            kvct_pkg::MODE_COMMENT: begin
               if (text_byte == kvct_pkg::CH_NEWLINE) begin
                  mode_in = kvct_pkg::MODE_SEEK;
               end
            end
            kvct_pkg::MODE_KEY: begin
               if (text_byte == kvct_pkg::CH_EQUAL || text_byte == kvct_pkg::CH_NEWLINE) begin
                  push.count = 2'd1;
                  push.r0    = mk(kvct_pkg::KIND_KEY, pbeg_ff, pend_ff, ovf_new, 1'b1);
                  mode_in    = (text_byte == kvct_pkg::CH_EQUAL) ? kvct_pkg::MODE_VSPACE
                                                                  : kvct_pkg::MODE_SEEK;
               end else if (!spc) begin
                  pend_in = nx;
               end
            end
            kvct_pkg::MODE_VSPACE, kvct_pkg::MODE_VALUE: begin
               // A value opens at the first byte that is not a space.
               if (!(mode_ff == kvct_pkg::MODE_VSPACE && text_byte == kvct_pkg::CH_SPACE)) begin
                  logic [kvct_pkg::OFFSET_BITS-1:0] b, e;
                  b = (mode_ff == kvct_pkg::MODE_VSPACE) ? pos_ff : pbeg_ff;
                  e = (mode_ff == kvct_pkg::MODE_VSPACE) ? pos_ff : pend_ff;
                  pbeg_in = b;
                  pend_in = e;
                  mode_in = kvct_pkg::MODE_VALUE;
                  if (text_byte == kvct_pkg::CH_NEWLINE || text_byte == kvct_pkg::CH_COMMA) begin
                     push.count = 2'd1;
                     push.r0    = mk(kvct_pkg::KIND_VAL, b, e, ovf_new, 1'b1);
                     mode_in    = (text_byte == kvct_pkg::CH_COMMA) ? kvct_pkg::MODE_VSPACE
                                                                     : kvct_pkg::MODE_SEEK;
                  end else if (!spc) begin
                     pend_in = nx;
                  end
               end
            end
            default: begin
               mode_in = kvct_pkg::MODE_SEEK;
               if (text_byte == kvct_pkg::CH_HASH) begin
                  mode_in = kvct_pkg::MODE_COMMENT;
               end else if (text_byte != kvct_pkg::CH_NEWLINE && !spc) begin
                  pbeg_in = pos_ff;
                  pend_in = nx;
                  mode_in = kvct_pkg::MODE_KEY;
               end
            end
         endcase
      end
   end

   // Scanner state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= kvct_pkg::MODE_SEEK;
         pos_ff  <= '0;
         pbeg_ff <= '0;
         pend_ff <= '0;
         ovf_ff  <= 1'b0;
      end else begin
         mode_ff <= mode_in;
         pos_ff  <= pos_in;
         pbeg_ff <= pbeg_in;
         pend_ff <= pend_in;
         ovf_ff  <= ovf_in;
      end
   end

`ifndef SYNTH
   a_rewind: assert property (@(posedge clock) disable iff (reset)
      (en && cmd == kvct_pkg::CMD_END) |=>
         (mode_ff == kvct_pkg::MODE_SEEK && pos_ff == '0 && !ovf_ff))
      else $error("scanner did not rewind after end of input");
   a_ovf_sat: assert property (@(posedge clock) disable iff (reset)
      ovf_ff |-> (pos_ff == kvct_pkg::POS_MAX))
      else $error("overflow flag set while position is not saturated");
   a_end_emits: assert property (@(posedge clock) disable iff (reset)
      (en && cmd == kvct_pkg::CMD_END) |-> (push.count != 2'd0))
      else $error("end of input produced no end-of-file token");
`endif

endmodule

[rtl/kvct_fifo.sv]
// Result queue that takes up to two tokens per cycle and hands out one.
module kvct_fifo (
   input  logic                      clock,
   input  logic                      reset,
   input  kvct_pkg::push_type        push,
   output logic                      room2,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output kvct_pkg::result_type      rsp_data
);

   kvct_pkg::result_type                mem [kvct_pkg::DEPTH];
   logic [kvct_pkg::PTR_BITS-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [kvct_pkg::PTR_BITS-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [kvct_pkg::CNT_BITS-1:0]       count_ff, count_in;
   logic                                pop;
   logic [kvct_pkg::PTR_BITS-1:0]       wr_ptr_nxt;

   // Pointer and occupancy update.
   always_comb begin
      rsp_valid  = (count_ff != '0);
      rsp_data   = mem[rd_ptr_ff];
      room2      = (count_ff <= kvct_pkg::CNT_BITS'(kvct_pkg::DEPTH - 2));
      pop        = rsp_valid && rsp_ready;
      wr_ptr_nxt = wr_ptr_ff + 1'b1;
      wr_ptr_in  = wr_ptr_ff + kvct_pkg::PTR_BITS'(push.count);
      rd_ptr_in  = rd_ptr_ff + kvct_pkg::PTR_BITS'(pop);
      count_in   = count_ff + kvct_pkg::CNT_BITS'(push.count) - kvct_pkg::CNT_BITS'(pop);
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage write.
   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem[wr_ptr_ff] <= push.r0;
      end
      if (push.count == 2'd2) begin
         mem[wr_ptr_nxt] <= push.r1;
      end
   end

`ifndef SYNTH
   a_no_over: assert property (@(posedge clock) disable iff (reset)
      count_ff <= kvct_pkg::CNT_BITS'(kvct_pkg::DEPTH))
      else $error("result queue occupancy beyond depth");
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      (push.count != 2'd0) |-> room2)
      else $error("tokens written into a queue without room");
   a_eof_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.kind == kvct_pkg::KIND_EOF) |-> rsp_data.last)
      else $error("end-of-file token without last mark");
`endif

endmodule

[rtl/key_value_config_tokenizer.sv]
// Top level of the key/value configuration tokenizer.
//
// The req_ channel carries one transaction per text byte (req_cmd low) or an
// end-of-buffer marker (req_cmd high). The rsp_ channel returns key, value and
// end-of-file tokens as begin and end byte offsets, with the overflow flag of
// the buffer and a last mark on the final token caused by each transaction.
// Both channels use valid/ready; a transaction moves when both are high.
// An accepted transaction waits in the input register until the result queue
// has room for two tokens; it is then decoded and its tokens are written into
// the queue registers, from which the receiver takes them. One
// transaction per cycle is sustained while each yields at most one token and
// the receiver keeps up: the scanner decodes one byte per cycle and the
// four-entry result queue takes up to two tokens per cycle. An end marker
// after a pending token yields two tokens, drained one per cycle while the
// receiver is ready. When it stalls, the queue fills; req_ready drops while
// the input register waits for two free entries. Nothing is lost or repeated.
// Reset clears the scanner to seeking a key at offset zero and empties the
// queue. After every end-of-file token the scanner rewinds the same way.
module key_value_config_tokenizer (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_cmd,
   input  logic [7:0]                     req_text_byte,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [1:0]                     rsp_token_kind,
   output logic [kvct_pkg::TOKEN_BITS-1:0] rsp_token_begin,
   output logic [kvct_pkg::TOKEN_BITS-1:0] rsp_token_end,
   output logic                           rsp_offset_overflow,
   output logic                           rsp_last_of_run
);

   logic                  in_valid_ff, in_valid_in;
   logic                  cmd_ff;
   logic [7:0]            byte_ff;
   logic                  room2;
   logic                  proceed;
   kvct_pkg::push_type    push;
   kvct_pkg::result_type  rsp_data;

   // Input register handshake.
   always_comb begin
      proceed     = in_valid_ff && room2;
      req_ready   = !in_valid_ff || proceed;
      in_valid_in = (req_valid && req_ready) || (in_valid_ff && !proceed);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         cmd_ff  <= req_cmd;
         byte_ff <= req_text_byte;
      end
   end

   kvct_scan u_scan (
      .clock     (clock),
      .reset     (reset),
      .en        (proceed),
      .cmd       (cmd_ff),
      .text_byte (byte_ff),
      .push      (push)
   );

   kvct_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room2     (room2),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // Result fields.
   assign rsp_token_kind      = rsp_data.kind;
   assign rsp_token_begin     = rsp_data.token_begin;
   assign rsp_token_end       = rsp_data.token_end;
   assign rsp_offset_overflow = rsp_data.overflow;
   assign rsp_last_of_run     = rsp_data.last;

endmodule

[test/key_value_config_tokenizer_tb.sv]
// Self-checking testbench for the key/value configuration tokenizer.
`timescale 1ns / 100ps

module key_value_config_tokenizer_tb;

   // Tracks the scanner state and the queue of tokens the block should return.
   class token_scoreboard;
      kvct_pkg::mode_type               scan;
      logic [kvct_pkg::OFFSET_BITS-1:0] next_pos;
      logic [kvct_pkg::OFFSET_BITS-1:0] tok_begin;
      logic [kvct_pkg::OFFSET_BITS-1:0] tok_end;
      bit                               saturated;
      kvct_pkg::result_type             expected_tokens[$];
      int                               errors;

      function void rewind();
         scan      = kvct_pkg::MODE_SEEK;
         next_pos  = '0;
         tok_begin = '0;
         tok_end   = '0;
         saturated = 1'b0;
      endfunction

      function bit is_blank(input logic [7:0] c);
         case (c)
            kvct_pkg::CH_SPACE, kvct_pkg::CH_TAB, kvct_pkg::CH_VTAB,
            kvct_pkg::CH_FF, kvct_pkg::CH_CR: return 1'b1;
            default: return 1'b0;
         endcase
      endfunction

      function void add_token(input kvct_pkg::kind_type k,
                              input logic [kvct_pkg::OFFSET_BITS-1:0] b,
                              input logic [kvct_pkg::OFFSET_BITS-1:0] e);
         kvct_pkg::result_type t;
         t.kind        = k;
         t.token_begin = b[kvct_pkg::TOKEN_BITS-1:0];
         t.token_end   = e[kvct_pkg::TOKEN_BITS-1:0];
         t.overflow    = saturated;
         t.last        = 1'b0;
         expected_tokens.push_back(t);
      endfunction

      // Advances the scanner by one accepted transaction.
      function void note_transaction(input logic cmd, input logic [7:0] c);
         int                               queued;
         logic [kvct_pkg::OFFSET_BITS-1:0] here;
         logic [kvct_pkg::OFFSET_BITS-1:0] step_pos;
         kvct_pkg::result_type             t;
         queued = expected_tokens.size();
         if (cmd == kvct_pkg::CMD_END) begin
            // Flush the open token, then report end of file and start over.
            case (scan)
               kvct_pkg::MODE_KEY:    add_token(kvct_pkg::KIND_KEY, tok_begin, tok_end);
               kvct_pkg::MODE_VSPACE: add_token(kvct_pkg::KIND_VAL, next_pos, next_pos);
               kvct_pkg::MODE_VALUE:  add_token(kvct_pkg::KIND_VAL, tok_begin, tok_end);
               default: ;
            endcase
            add_token(kvct_pkg::KIND_EOF, '0, '0);
            rewind();
         end else begin
            // The position sticks at its maximum once it gets there.
            here = next_pos;
            if (here == kvct_pkg::POS_MAX) begin
               step_pos  = kvct_pkg::POS_MAX;
               saturated = 1'b1;
            end else begin
               step_pos = here + 1'b1;
            end
            next_pos = step_pos;
            case (scan)
               kvct_pkg::MODE_COMMENT: begin
                  if (c == kvct_pkg::CH_NEWLINE) scan = kvct_pkg::MODE_SEEK;
               end
               kvct_pkg::MODE_KEY: begin
                  if (c == kvct_pkg::CH_EQUAL) begin
                     add_token(kvct_pkg::KIND_KEY, tok_begin, tok_end);
                     scan = kvct_pkg::MODE_VSPACE;
                  end else if (c == kvct_pkg::CH_NEWLINE) begin
                     add_token(kvct_pkg::KIND_KEY, tok_begin, tok_end);
                     scan = kvct_pkg::MODE_SEEK;
                  end else if (!is_blank(c)) begin
                     tok_end = step_pos;
                  end
               end
               kvct_pkg::MODE_VSPACE, kvct_pkg::MODE_VALUE: begin
                  // Only plain spaces are skipped ahead of a value.
                  if (!(scan == kvct_pkg::MODE_VSPACE && c == kvct_pkg::CH_SPACE)) begin
                     if (scan == kvct_pkg::MODE_VSPACE) begin
                        tok_begin = here;
                        tok_end   = here;
                        scan      = kvct_pkg::MODE_VALUE;
                     end
                     if (c == kvct_pkg::CH_NEWLINE) begin
                        add_token(kvct_pkg::KIND_VAL, tok_begin, tok_end);
                        scan = kvct_pkg::MODE_SEEK;
                     end else if (c == kvct_pkg::CH_COMMA) begin
                        add_token(kvct_pkg::KIND_VAL, tok_begin, tok_end);
                        scan = kvct_pkg::MODE_VSPACE;
                     end else if (!is_blank(c)) begin
                        tok_end = step_pos;
                     end
                  end
               end
               default: begin
                  scan = kvct_pkg::MODE_SEEK;
                  if (c == kvct_pkg::CH_HASH) begin
                     scan = kvct_pkg::MODE_COMMENT;
                  end else if (c != kvct_pkg::CH_NEWLINE && !is_blank(c)) begin
                     tok_begin = here;
                     tok_end   = step_pos;
                     scan      = kvct_pkg::MODE_KEY;
                  end
               end
            endcase
         end
         // Mark the final token of this transaction.
         if (expected_tokens.size() > queued) begin
            t = expected_tokens.pop_back();
            t.last = 1'b1;
            expected_tokens.push_back(t);
         end
      endfunction

      function void compare_field(input string what, input logic [31:0] want,
                                  input logic [31:0] got);
         if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
         end
      endfunction

      // Compares one returned token with the oldest expected one.
      function void check_token(input logic [1:0] got_kind,
                                input logic [kvct_pkg::TOKEN_BITS-1:0] got_begin,
                                input logic [kvct_pkg::TOKEN_BITS-1:0] got_end,
                                input logic got_overflow, input logic got_last);
         kvct_pkg::result_type want;
         if (expected_tokens.size() == 0) begin
            errors++;
            $display("%0t: token kind %0d begin %0d end %0d arrived with none expected",
                     $time, got_kind, got_begin, got_end);
            return;
         end
         want = expected_tokens.pop_front();
         compare_field("token_kind", want.kind, got_kind);
         compare_field("token_begin", want.token_begin, got_begin);
         compare_field("token_end", want.token_end, got_end);
         compare_field("offset_overflow", want.overflow, got_overflow);
         compare_field("last_of_run", want.last, got_last);
      endfunction
   endclass

   typedef enum int {READY_ALWAYS, READY_MOSTLY, READY_SELDOM, READY_PERIODIC} ready_style_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_ready;
   logic                            req_cmd = kvct_pkg::CMD_BYTE;
   logic [7:0]                      req_text_byte = 8'h00;
   logic                            rsp_valid;
   logic                            rsp_ready = 1'b0;
   logic [1:0]                      rsp_token_kind;
   logic [kvct_pkg::TOKEN_BITS-1:0] rsp_token_begin;
   logic [kvct_pkg::TOKEN_BITS-1:0] rsp_token_end;
   logic                            rsp_offset_overflow;
   logic                            rsp_last_of_run;

   token_scoreboard tokens;
   int              sent_items = 0;
   int              burst_left = 0;
   logic [7:0]      line_bytes[$];
   ready_style_type ready_style = READY_ALWAYS;
   int              ready_hold = 0;
   logic [7:0]      ready_tick = '0;

   key_value_config_tokenizer DUT (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_cmd             (req_cmd),
      .req_text_byte       (req_text_byte),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_token_kind      (rsp_token_kind),
      .rsp_token_begin     (rsp_token_begin),
      .rsp_token_end       (rsp_token_end),
      .rsp_offset_overflow (rsp_offset_overflow),
      .rsp_last_of_run     (rsp_last_of_run)
   );

   always #2 clock = ~clock;

   // Receiver: switches between stall styles, each held for a random span.
   always @(negedge clock) begin
      if (ready_hold == 0) begin
         ready_style = ready_style_type'($urandom_range(0, 3));
         ready_hold  = $urandom_range(16, 160);
      end
      ready_hold--;
      ready_tick++;
      case (ready_style)
         READY_ALWAYS: rsp_ready <= 1'b1;
         READY_MOSTLY: rsp_ready <= ($urandom_range(0, 3) != 0);
         READY_SELDOM: rsp_ready <= ($urandom_range(0, 3) == 0);
         default:      rsp_ready <= (ready_tick[2:0] < 3'd5);
      endcase
   end

   // Check every token transaction on the result side.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         tokens.check_token(rsp_token_kind, rsp_token_begin, rsp_token_end,
                            rsp_offset_overflow, rsp_last_of_run);
   end

   // Sends one transaction; the sender may idle between bursts of random length.
   task automatic put_item(input logic cmd, input logic [7:0] value);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         repeat (gap) begin
            @(negedge clock);
            req_valid <= 1'b0;
         end
         burst_left = $urandom_range(1, 40);
      end
      if (burst_left > 0) burst_left--;
      @(negedge clock);
      req_valid     <= 1'b1;
      req_cmd       <= cmd;
      req_text_byte <= value;
      do @(posedge clock); while (!req_ready);
      tokens.note_transaction(cmd, value);
      sent_items++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) put_item(kvct_pkg::CMD_BYTE, s[i]);
   endtask

   task automatic send_end();
      put_item(kvct_pkg::CMD_END, 8'($urandom));
   endtask

   function automatic logic [7:0] blank_char();
      case ($urandom_range(0, 7))
         0:       return kvct_pkg::CH_TAB;
         1:       return kvct_pkg::CH_CR;
         2:       return kvct_pkg::CH_VTAB;
         3:       return kvct_pkg::CH_FF;
         default: return kvct_pkg::CH_SPACE;
      endcase
   endfunction

   function automatic void add_blanks(input int n);
      repeat (n) line_bytes.push_back(blank_char());
   endfunction

   // A word of printable bytes, sometimes with whitespace inside it.
   function automatic void add_word(input int n);
      logic [7:0] c;
      for (int i = 0; i < n; i++) begin
         if (i > 0 && i < n - 1 && $urandom_range(0, 7) == 0) begin
            c = blank_char();
         end else begin
            do c = 8'($urandom_range(33, 126));
            while (c == kvct_pkg::CH_EQUAL || c == kvct_pkg::CH_COMMA);
         end
         line_bytes.push_back(c);
      end
   endfunction

   // Builds one line of text: mostly key/value lines, with comments, blank lines, bare keys and noise.
   function automatic void build_line();
      int         pick;
      int         nvals;
      logic [7:0] c;
      line_bytes.delete();
      pick = $urandom_range(0, 11);
      if (pick == 0) begin
         line_bytes.push_back(kvct_pkg::CH_HASH);
         repeat ($urandom_range(0, 8)) begin
            do c = 8'($urandom); while (c == kvct_pkg::CH_NEWLINE);
            line_bytes.push_back(c);
         end
         line_bytes.push_back(kvct_pkg::CH_NEWLINE);
      end else if (pick == 1) begin
         add_blanks($urandom_range(0, 3));
         line_bytes.push_back(kvct_pkg::CH_NEWLINE);
      end else if (pick == 2) begin
         repeat ($urandom_range(1, 8)) line_bytes.push_back(8'($urandom));
      end else begin
         add_blanks($urandom_range(0, 2));
         add_word($urandom_range(1, 6));
         add_blanks($urandom_range(0, 2));
         if (pick != 3) begin
            line_bytes.push_back(kvct_pkg::CH_EQUAL);
            nvals = $urandom_range(1, 4);
            for (int v = 0; v < nvals; v++) begin
               if (v > 0) line_bytes.push_back(kvct_pkg::CH_COMMA);
               repeat ($urandom_range(0, 3)) line_bytes.push_back(kvct_pkg::CH_SPACE);
               if ($urandom_range(0, 5) == 0) line_bytes.push_back(blank_char());
               add_word($urandom_range(0, 5));
               add_blanks($urandom_range(0, 2));
            end
         end
         line_bytes.push_back(kvct_pkg::CH_NEWLINE);
      end
   endfunction

   initial begin
      int goal;
      int cut;
      tokens = new();
      tokens.rewind();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: comments, both key endings, value trimming, end of input in every mode but a value.
      send_text("#x\n");
      put_item(kvct_pkg::CMD_BYTE, 8'h00);
      send_text(" =");
      send_text("\t v\015,");
      send_end();
      put_item(kvct_pkg::CMD_BYTE, 8'hFF);
      send_text("k");
      send_end();
      send_text("a\nb=  c \n");
      send_text("#");
      send_end();
      send_end();
      send_text("k=");
      send_end();

      // Random buffers of mostly well-formed lines, some cut short by end of input.
      goal = sent_items + 1850;
      while (sent_items < goal) begin
         repeat ($urandom_range(1, 6)) begin
            build_line();
            cut = line_bytes.size();
            if ($urandom_range(0, 9) == 0) cut = $urandom_range(0, cut - 1);
            for (int i = 0; i < cut; i++) put_item(kvct_pkg::CMD_BYTE, line_bytes[i]);
         end
         send_end();
      end

      @(negedge clock);
      req_valid <= 1'b0;
      while (tokens.expected_tokens.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (tokens.errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // Watchdog well beyond the slowest correct run.
   initial begin
      #2_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

[sim.f]
rtl/kvct_pkg.sv
rtl/kvct_scan.sv
rtl/kvct_fifo.sv
rtl/key_value_config_tokenizer.sv
test/key_value_config_tokenizer_tb.sv
